>>> design/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

	localparam int MAX_TASKS       = 16;
	localparam int PRIORITY_LEVELS = 4;
	localparam int IDX_W           = 4;
	localparam int PRI_W           = 2;
	localparam int TIME_W          = 32;
	localparam int CNT_W           = 5;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [PRI_W-1:0]  pri_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam pri_t PRI_MAX = pri_t'(PRIORITY_LEVELS - 1);
	localparam cnt_t CNT_MAX = cnt_t'(MAX_TASKS);

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_CHECK,
		S_FINISH
	} state_t;

	typedef struct packed {
		time_t period;
		time_t lr;
		pri_t  pri;
	} tbl_entry_t;

	// load_we writes the whole entry, lr_we only the last-release time
	typedef struct packed {
		logic  load_we;
		logic  lr_we;
		idx_t  idx;
		time_t period;
		time_t lr;
		pri_t  pri;
	} tbl_wr_t;

endpackage
`default_nettype wire

>>> design/ptd_table.sv
`default_nettype none
module ptd_table import ptd_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  tbl_wr_t    wr,
	input  idx_t       rd_idx,
	output tbl_entry_t rd
);

	tbl_entry_t mem_q [MAX_TASKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr.load_we) begin
			mem_q[wr.idx] <= '{period: wr.period, lr: wr.lr, pri: wr.pri};
		end else if (wr.lr_we) begin
			mem_q[wr.idx].lr <= wr.lr;
		end
	end

	assign rd = mem_q[rd_idx];

endmodule
`default_nettype wire

>>> design/ptd_alu.sv
`default_nettype none
module ptd_alu import ptd_pkg::*; (
	input  wire   sub,
	input  time_t a,
	input  time_t b,
	output time_t sum,
	input  time_t cmp_x,
	input  time_t cmp_y,
	output logic  ge
);

	// one 32-bit adder, subtract by inverting b and carrying in
	assign sum = a + (b ^ {TIME_W{sub}}) + time_t'(sub);
	assign ge  = (cmp_x >= cmp_y);

endmodule
`default_nettype wire

>>> design/periodic_task_dispatcher_unit.sv
`default_nettype none
// channel | dir | signals                         | contents (low bit up)
// --------+-----+---------------------------------+-------------------------------------------
// s_      | in  | s_tvalid s_tready s_tdata s_tuser | tuser: op; tdata: now_ms, entry_index,
//         |     |                                 |   entry_period, entry_start, entry_priority
// m_      | out | m_tvalid m_tready m_tdata m_tuser | tuser: released; tdata: task_index;
//         |     | m_tlast                         |   tlast: last
// cfg_    | in  | cfg_we cfg_wdata                | task_count
//
// A load writes the entry on acceptance; the ack leaves from FINISH once the output register is free.
// A scan visits each of the first n entries (n at most 16) once per priority level in EVAL, and
// the entry whose level matches goes on to CHECK, where the release test runs.
// The single table read port and the shared adder keep these visits one after another.
// Reset clears the task table, task_count and all control; no clearing pass is needed.
// A release found while the previous one still waits for the output register stalls the scan.
module periodic_task_dispatcher_unit import ptd_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [103:0] s_tdata,  // now_ms, entry_index, entry_period, entry_start, entry_priority
	input  wire          s_tuser,  // op
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [7:0]   m_tdata,  // task_index
	output logic         m_tuser,  // released
	output logic         m_tlast,  // last
	input  wire          cfg_we,
	input  wire  [4:0]   cfg_wdata // task_count
);

	// input field split
	time_t in_now;
	idx_t  in_idx;
	time_t in_period;
	time_t in_start;
	pri_t  in_pri;
	pri_t  in_pri_sat;
	cnt_t  n_in;

	assign in_now    = s_tdata[31:0];
	assign in_idx    = s_tdata[35:32];
	assign in_period = s_tdata[67:36];
	assign in_start  = s_tdata[99:68];
	assign in_pri    = s_tdata[101:100];
	// saturate to the top level; entry_index always fits the table
	assign in_pri_sat = (in_pri > PRI_MAX) ? PRI_MAX : in_pri;

	// registers
	state_t state_q, state_d;
	cnt_t   task_count_q;
	cnt_t   n_q;
	time_t  now_q;
	time_t  diff_q;
	idx_t   idx_q;
	pri_t   pri_q;
	logic   pend_v_q;
	idx_t   pend_idx_q;
	logic   m_valid_q;
	logic   m_rel_q;
	idx_t   m_idx_q;
	logic   m_last_q;

	// control
	logic       accept;
	logic       step;
	logic       diff_ld;
	logic       pend_ld;
	logic       out_ld;
	logic       out_rel;
	idx_t       out_idx;
	logic       out_last;
	logic       out_free;
	logic       last_idx;
	tbl_wr_t    tbl_wr;
	tbl_entry_t rd;
	logic       alu_sub;
	time_t      alu_a;
	time_t      alu_b;
	time_t      alu_sum;
	logic       ge;

	assign n_in     = (task_count_q > CNT_MAX) ? CNT_MAX : task_count_q;
	assign out_free = !m_valid_q || m_tready;
	assign last_idx = ({1'b0, idx_q} == cnt_t'(n_q - cnt_t'(1)));

	ptd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.rd_idx (idx_q),
		.rd     (rd)
	);

	// EVAL: elapsed = now - last_release; CHECK: last_release + period
	ptd_alu u_alu (
		.sub   (alu_sub),
		.a     (alu_a),
		.b     (alu_b),
		.sum   (alu_sum),
		.cmp_x (diff_q),
		.cmp_y (rd.period),
		.ge    (ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		step     = 1'b0;
		diff_ld  = 1'b0;
		pend_ld  = 1'b0;
		out_ld   = 1'b0;
		out_rel  = 1'b0;
		out_idx  = '0;
		out_last = 1'b0;
		alu_sub  = 1'b1;
		alu_a    = now_q;
		alu_b    = rd.lr;
		tbl_wr   = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept = 1'b1;
					if (op_t'(s_tuser) == OP_LOAD) begin
						tbl_wr.load_we = 1'b1;
						tbl_wr.idx     = in_idx;
						tbl_wr.period  = in_period;
						tbl_wr.lr      = in_start;
						tbl_wr.pri     = in_pri_sat;
						state_d        = S_FINISH;
					end else if (n_in == '0) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				if (rd.pri == pri_q) begin
					diff_ld = 1'b1;
					state_d = S_CHECK;
				end else begin
					step = 1'b1;
				end
			end
			S_CHECK: begin
				alu_sub = 1'b0;
				alu_a   = rd.lr;
				alu_b   = rd.period;
				if (!ge) begin
					step = 1'b1;
				end else if (!pend_v_q || out_free) begin
					// previous release is now known not to be the final one
					tbl_wr.lr_we = 1'b1;
					tbl_wr.idx   = idx_q;
					tbl_wr.lr    = alu_sum;
					pend_ld      = 1'b1;
					out_ld       = pend_v_q;
					out_rel      = 1'b1;
					out_idx      = pend_idx_q;
					step         = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_rel  = pend_v_q;
					out_idx  = pend_v_q ? pend_idx_q : '0;
					out_last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (step) begin
			state_d = (last_idx && pri_q == PRI_MAX) ? S_FINISH : S_EVAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			idx_q        <= '0;
			pri_q        <= '0;
			n_q          <= '0;
			pend_v_q     <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				task_count_q <= cfg_wdata;
			end
			if (accept) begin
				idx_q    <= '0;
				pri_q    <= '0;
				n_q      <= n_in;
				pend_v_q <= 1'b0;
			end else if (step) begin
				if (last_idx) begin
					idx_q <= '0;
					pri_q <= pri_q + pri_t'(1);
				end else begin
					idx_q <= idx_q + idx_t'(1);
				end
			end
			if (pend_ld) begin
				pend_v_q <= 1'b1;
			end
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_now;
		end
		if (diff_ld) begin
			diff_q <= alu_sum;
		end
		if (pend_ld) begin
			pend_idx_q <= idx_q;
		end
		if (out_ld) begin
			m_rel_q  <= out_rel;
			m_idx_q  <= out_idx;
			m_last_q <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_idx_q};
	assign m_tuser  = m_rel_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire
